@@ sv/sst_pkg.sv @@
// Package for the source tokenizer: token codes, scan modes, keyword matching.
// No dependencies.
package sst_pkg;

  localparam int unsigned SOURCE_BYTES_DEF = 65536;
  localparam int unsigned MAX_LINES_DEF    = 65535;
  localparam int unsigned WORD_MAX         = 9;
  localparam int unsigned TOK_W            = 58;
  localparam int unsigned QUEUE_DEPTH      = 4;

  typedef enum logic [4:0] {
    M_IDLE      = 5'd0,
    M_IDENT     = 5'd1,
    M_INT       = 5'd2,
    M_NUMDOT    = 5'd3,
    M_FRAC      = 5'd4,
    M_STRING    = 5'd5,
    M_CHAROPEN  = 5'd6,
    M_CHARBODY  = 5'd7,
    M_SLASH     = 5'd8,
    M_LINESTART = 5'd9,
    M_LINE      = 5'd10,
    M_BLOCK     = 5'd11,
    M_BLOCKSTAR = 5'd12,
    M_OP_AND    = 5'd13,
    M_OP_OR     = 5'd14,
    M_OP_DOT    = 5'd15,
    M_OP_MINUS  = 5'd16,
    M_OP_PLUS   = 5'd17,
    M_OP_STAR   = 5'd18,
    M_OP_BANG   = 5'd19,
    M_OP_EQ     = 5'd20,
    M_OP_LT     = 5'd21,
    M_OP_GT     = 5'd22
  } scan_mode_t;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_NUMBER = 6'd1;
  localparam logic [5:0] K_IDENT  = 6'd2;
  localparam logic [5:0] K_STRING = 6'd3;
  localparam logic [5:0] K_CHAR   = 6'd4;
  localparam logic [5:0] K_ERROR  = 6'd5;
  localparam logic [5:0] K_KW0    = 6'd6;
  localparam logic [5:0] K_LPAREN = 6'd29;
  localparam logic [5:0] K_RPAREN = 6'd30;
  localparam logic [5:0] K_LBRACE = 6'd31;
  localparam logic [5:0] K_RBRACE = 6'd32;
  localparam logic [5:0] K_SEMI   = 6'd33;
  localparam logic [5:0] K_COMMA  = 6'd34;
  localparam logic [5:0] K_DOT    = 6'd35;
  localparam logic [5:0] K_RANGE  = 6'd36;
  localparam logic [5:0] K_SLASH  = 6'd41;
  localparam logic [5:0] K_SLASHEQ = 6'd42;
  localparam logic [5:0] K_COLON  = 6'd45;

  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_UNTERM_STR = 3'd1;
  localparam logic [2:0] E_EMPTY_CHAR = 3'd2;
  localparam logic [2:0] E_NO_QUOTE   = 3'd3;
  localparam logic [2:0] E_UNEXPECTED = 3'd4;

  // One emitted token.
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [2:0]  err;
    logic        last;
  } token_t;

  // Classification of one byte, produced by the front end.
  typedef struct packed {
    logic [7:0] c;
    logic       at_end;
    logic       digit;
    logic       alpha;
    logic       space;
    logic       nl;
    logic       pair;
    logic [4:0] pair_mode;
  } byte_class_t;

  typedef logic [WORD_MAX-1:0][7:0] word_t;

  function automatic logic [5:0] pair_one(input scan_mode_t m);
    case (m)
      M_OP_AND:   return 6'd54;
      M_OP_OR:    return 6'd56;
      M_OP_DOT:   return 6'd35;
      M_OP_MINUS: return 6'd37;
      M_OP_PLUS:  return 6'd39;
      M_OP_STAR:  return 6'd43;
      M_OP_BANG:  return 6'd46;
      M_OP_EQ:    return 6'd48;
      M_OP_LT:    return 6'd50;
      default:    return 6'd52;
    endcase
  endfunction

  function automatic logic [7:0] pair_second(input scan_mode_t m);
    case (m)
      M_OP_AND: return 8'h26;
      M_OP_OR:  return 8'h7C;
      M_OP_DOT: return 8'h2E;
      default:  return 8'h3D;
    endcase
  endfunction

  // Keyword lookup over a buffered word; bytes past wlen are ignored.
  function automatic logic [5:0] word_kind(input word_t w, input logic [3:0] wlen);
    logic [71:0] s;
    logic [5:0]  k;
    s = '0;
    k = K_IDENT;
    for (int i = 0; i < WORD_MAX; i++) begin
      if (i < wlen) s[i*8 +: 8] = w[i];
    end
    case (wlen)
      4'd2: if (s[15:0] == "fi") k = 6'd11;
      4'd3: begin
        if (s[23:0] == "lin") k = 6'd12;
        else if (s[23:0] == "rav") k = 6'd17;
        else if (s[23:0] == "rof") k = 6'd20;
        else if (s[23:0] == "nuf") k = 6'd21;
      end
      4'd4: begin
        if (s[31:0] == "esle") k = 6'd10;
        else if (s[31:0] == "siht") k = 6'd23;
        else if (s[31:0] == "eurt") k = 6'd24;
      end
      4'd5: begin
        if (s[39:0] == "kaerb") k = 6'd7;
        else if (s[39:0] == "ssalc") k = 6'd8;
        else if (s[39:0] == "repus") k = 6'd14;
        else if (s[39:0] == "elihw") k = 6'd18;
        else if (s[39:0] == "eslaf") k = 6'd19;
        else if (s[39:0] == "lanif") k = 6'd22;
      end
      4'd6: begin
        if (s[47:0] == "nruter") k = 6'd13;
        else if (s[47:0] == "hctiws") k = 6'd15;
        else if (s[47:0] == "citats") k = 6'd16;
        else if (s[47:0] == "cilbup") k = 6'd26;
      end
      4'd7: if (s[55:0] == "etavirp") k = 6'd27;
      4'd8: begin
        if (s[63:0] == "tcartsba") k = 6'd6;
        else if (s[63:0] == "eunitnoc") k = 6'd9;
        else if (s[63:0] == "edirrevo") k = 6'd25;
      end
      4'd9: if (s[71:0] == "detcetorp") k = 6'd28;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

@@ sv/sst_front.sv @@
// Front end: accepts source bytes and classifies each into a byte_class_t.
// Depends on sst_pkg.
module sst_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_end,
  output logic                q_valid,
  input  logic                q_ready,
  output sst_pkg::byte_class_t q_data
);
  import sst_pkg::*;

  byte_class_t cls;
  logic        full;

  always_comb begin
    cls = '0;
    cls.c = in_byte;
    cls.at_end = in_end | (in_byte == 8'd0);
    cls.digit = (in_byte >= "0") && (in_byte <= "9");
    cls.alpha = ((in_byte >= "a") && (in_byte <= "z")) ||
                ((in_byte >= "A") && (in_byte <= "Z")) || (in_byte == "_");
    cls.space = (in_byte == " ") || (in_byte == 8'h0D) || (in_byte == 8'h09);
    cls.nl = (in_byte == 8'h0A);
    cls.pair = 1'b1;
    case (in_byte)
      "&":     cls.pair_mode = M_OP_AND;
      "|":     cls.pair_mode = M_OP_OR;
      ".":     cls.pair_mode = M_OP_DOT;
      "-":     cls.pair_mode = M_OP_MINUS;
      "+":     cls.pair_mode = M_OP_PLUS;
      "*":     cls.pair_mode = M_OP_STAR;
      "!":     cls.pair_mode = M_OP_BANG;
      "=":     cls.pair_mode = M_OP_EQ;
      "<":     cls.pair_mode = M_OP_LT;
      ">":     cls.pair_mode = M_OP_GT;
      default: begin
        cls.pair = 1'b0;
        cls.pair_mode = M_IDLE;
      end
    endcase
  end

  // Single register stage; refills in the cycle it drains.
  assign in_ready = !full || q_ready;
  assign q_valid  = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_data <= cls;
    end
  end

endmodule

@@ sv/sst_back.sv @@
// Back end: scan state machine; turns classified bytes into up to three
// tokens per byte, pushed into an output queue. Depends on sst_pkg.
module sst_back #(
  parameter int unsigned SOURCE_BYTES = sst_pkg::SOURCE_BYTES_DEF,
  parameter int unsigned MAX_LINES    = sst_pkg::MAX_LINES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sst_pkg::byte_class_t q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sst_pkg::token_t      out_token
);
  import sst_pkg::*;

  localparam logic [15:0] POS_LIM  = (SOURCE_BYTES - 1 > 65535) ? 16'hFFFF
                                     : 16'(SOURCE_BYTES - 1);
  localparam logic [15:0] LINE_LIM = (MAX_LINES > 65535) ? 16'hFFFF : 16'(MAX_LINES);
  localparam int unsigned QA = $clog2(QUEUE_DEPTH);

  scan_mode_t  mode, mode_next;
  logic [15:0] pos, pos_next;
  logic [15:0] line, line_next;
  logic [15:0] tbeg, tbeg_next;
  word_t       word, word_next;
  logic [3:0]  wlen, wlen_next;
  logic        stopped, stopped_next;

  token_t     tok [3];
  logic [1:0] ntok;

  // token queue
  token_t      qmem [QUEUE_DEPTH];
  logic [QA-1:0] rd, wr;
  logic [QA:0]   cnt;
  logic          take;

  // length of a span that includes the current byte, saturating
  function automatic logic [15:0] sat_len(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  assign q_ready = (cnt <= 3'(QUEUE_DEPTH - 3)) || ((cnt == 3'(QUEUE_DEPTH - 2)) && out_ready);
  assign take    = q_valid && q_ready;

  always_comb begin
    logic [7:0]  c;
    logic [15:0] here, dp;
    logic        restart;
    logic [15:0] s [3];
    logic [15:0] ln [3];
    logic [5:0]  kd [3];
    logic [2:0]  er [3];

    c = q_data.c;
    here = pos;
    mode_next = mode;
    pos_next = pos;
    line_next = line;
    tbeg_next = tbeg;
    word_next = word;
    wlen_next = wlen;
    stopped_next = stopped;
    ntok = 2'd0;
    restart = 1'b0;
    dp = (pos > tbeg) ? pos - 16'd1 : tbeg;
    for (int i = 0; i < 3; i++) begin
      s[i] = '0; ln[i] = '0; kd[i] = '0; er[i] = E_NONE;
    end

    if (q_data.at_end) begin
      if (!stopped) begin
        case (mode)
          M_IDENT: begin
            kd[0] = word_kind(word, wlen); s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1;
          end
          M_INT, M_FRAC: begin
            kd[0] = K_NUMBER; s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1;
          end
          M_NUMDOT: begin
            kd[0] = K_NUMBER; s[0] = tbeg; ln[0] = dp - tbeg;
            kd[1] = K_DOT; s[1] = dp; ln[1] = 16'd1; ntok = 2'd2;
          end
          M_STRING: begin
            kd[0] = K_ERROR; s[0] = tbeg; ln[0] = here - tbeg; er[0] = E_UNTERM_STR;
            ntok = 2'd1;
          end
          M_CHAROPEN, M_CHARBODY: begin
            kd[0] = K_ERROR; s[0] = tbeg; ln[0] = here - tbeg; er[0] = E_NO_QUOTE;
            ntok = 2'd1;
          end
          M_SLASH: begin
            kd[0] = K_SLASH; s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1;
          end
          M_OP_AND, M_OP_OR, M_OP_DOT, M_OP_MINUS, M_OP_PLUS, M_OP_STAR,
          M_OP_BANG, M_OP_EQ, M_OP_LT, M_OP_GT: begin
            kd[0] = pair_one(mode); s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1;
          end
          default: ntok = 2'd0;
        endcase
      end
      kd[ntok] = K_EOF; s[ntok] = stopped ? tbeg : pos; ln[ntok] = '0;
      ntok = ntok + 2'd1;
      mode_next = M_IDLE; pos_next = '0; line_next = 16'd1; tbeg_next = '0;
      wlen_next = '0; stopped_next = 1'b0;
    end else if (!stopped) begin
      case (mode)
        M_IDENT: begin
          if (q_data.alpha || q_data.digit) begin
            if (wlen < 4'(WORD_MAX)) word_next[wlen[3:0] < 4'(WORD_MAX) ? wlen : '0] = c;
            if (wlen < 4'd15) wlen_next = wlen + 4'd1;
          end else begin
            kd[0] = word_kind(word, wlen); s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1;
            restart = 1'b1;
          end
        end
        M_INT: begin
          if (c == ".") mode_next = M_NUMDOT;
          else if (!q_data.digit) begin
            kd[0] = K_NUMBER; s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1; restart = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (q_data.digit) mode_next = M_FRAC;
          else begin
            kd[0] = K_NUMBER; s[0] = tbeg; ln[0] = dp - tbeg;
            if (c == ".") begin
              kd[1] = K_RANGE; s[1] = dp;
              ln[1] = sat_len(17'(here) + 17'd1 - 17'(dp)); ntok = 2'd2;
              mode_next = M_IDLE;
            end else begin
              kd[1] = K_DOT; s[1] = dp; ln[1] = 16'd1; ntok = 2'd2; restart = 1'b1;
            end
          end
        end
        M_FRAC: begin
          if (!q_data.digit) begin
            kd[0] = K_NUMBER; s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1; restart = 1'b1;
          end
        end
        M_STRING: begin
          if (c == 8'h22) begin
            kd[0] = K_STRING; s[0] = tbeg;
            ln[0] = sat_len(17'(here) + 17'd1 - 17'(tbeg)); ntok = 2'd1;
            mode_next = M_IDLE;
          end else if (q_data.nl && line < LINE_LIM) line_next = line + 16'd1;
        end
        M_CHAROPEN: begin
          if (c == 8'h27) begin
            kd[0] = K_ERROR; s[0] = tbeg; ln[0] = here - tbeg; er[0] = E_EMPTY_CHAR;
            ntok = 2'd1; restart = 1'b1;
          end else mode_next = M_CHARBODY;
        end
        M_CHARBODY: begin
          if (c == 8'h27) begin
            kd[0] = K_CHAR; s[0] = tbeg;
            ln[0] = sat_len(17'(here) + 17'd1 - 17'(tbeg)); ntok = 2'd1;
            mode_next = M_IDLE;
          end else begin
            kd[0] = K_ERROR; s[0] = tbeg; ln[0] = here - tbeg; er[0] = E_NO_QUOTE;
            ntok = 2'd1; restart = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            tbeg_next = here; mode_next = M_LINESTART;
          end else if (c == "*") mode_next = M_BLOCK;
          else if (c == "=") begin
            kd[0] = K_SLASHEQ; s[0] = tbeg;
            ln[0] = sat_len(17'(here) + 17'd1 - 17'(tbeg)); ntok = 2'd1;
            mode_next = M_IDLE;
          end else begin
            kd[0] = K_SLASH; s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1; restart = 1'b1;
          end
        end
        M_LINESTART: begin
          if (c == "*") begin
            stopped_next = 1'b1; mode_next = M_IDLE;
          end else if (q_data.nl) begin
            if (line < LINE_LIM) line_next = line + 16'd1;
            mode_next = M_IDLE;
          end else mode_next = M_LINE;
        end
        M_LINE: begin
          if (q_data.nl) begin
            if (line < LINE_LIM) line_next = line + 16'd1;
            mode_next = M_IDLE;
          end
        end
        M_BLOCK: begin
          if (c == "*") mode_next = M_BLOCKSTAR;
          else if (q_data.nl && line < LINE_LIM) line_next = line + 16'd1;
        end
        M_BLOCKSTAR: begin
          if (c == "/") mode_next = M_IDLE;
          else if (q_data.nl) begin
            if (line < LINE_LIM) line_next = line + 16'd1;
            mode_next = M_BLOCK;
          end else if (c != "*") mode_next = M_BLOCK;
        end
        M_OP_AND, M_OP_OR, M_OP_DOT, M_OP_MINUS, M_OP_PLUS, M_OP_STAR,
        M_OP_BANG, M_OP_EQ, M_OP_LT, M_OP_GT: begin
          if (c == pair_second(mode)) begin
            kd[0] = pair_one(mode) + 6'd1; s[0] = tbeg;
            ln[0] = sat_len(17'(here) + 17'd1 - 17'(tbeg));
            ntok = 2'd1; mode_next = M_IDLE;
          end else begin
            kd[0] = pair_one(mode); s[0] = tbeg; ln[0] = here - tbeg; ntok = 2'd1;
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      if (restart) begin
        tbeg_next = here;
        mode_next = M_IDLE;
        if (q_data.nl) begin
          if (line < LINE_LIM) line_next = line + 16'd1;
        end else if (q_data.space) begin
          mode_next = M_IDLE;
        end else if (q_data.digit) mode_next = M_INT;
        else if (q_data.alpha) begin
          word_next[0] = c; wlen_next = 4'd1; mode_next = M_IDENT;
        end else if (c == 8'h22) mode_next = M_STRING;
        else if (c == 8'h27) mode_next = M_CHAROPEN;
        else if (c == "/") mode_next = M_SLASH;
        else if (q_data.pair) mode_next = scan_mode_t'(q_data.pair_mode);
        else begin
          s[ntok] = here; ln[ntok] = 16'd1; er[ntok] = E_NONE;
          case (c)
            "(":     kd[ntok] = K_LPAREN;
            ")":     kd[ntok] = K_RPAREN;
            "{":     kd[ntok] = K_LBRACE;
            "}":     kd[ntok] = K_RBRACE;
            ";":     kd[ntok] = K_SEMI;
            ",":     kd[ntok] = K_COMMA;
            ":":     kd[ntok] = K_COLON;
            default: begin
              kd[ntok] = K_ERROR; er[ntok] = E_UNEXPECTED;
            end
          endcase
          ntok = ntok + 2'd1;
        end
      end
      if (pos < POS_LIM) pos_next = pos + 16'd1;
    end

    // every token of a step is emitted before that step's own newline work,
    // so all of them carry the line value held before the byte
    for (int i = 0; i < 3; i++) begin
      tok[i].kind = kd[i];
      tok[i].start = s[i];
      tok[i].length = ln[i];
      tok[i].line = line;
      tok[i].err = er[i];
      tok[i].last = (2'(i) == ntok - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pos <= '0;
      line <= 16'd1;
      tbeg <= '0;
      wlen <= '0;
      stopped <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      pos <= pos_next;
      line <= line_next;
      tbeg <= tbeg_next;
      wlen <= wlen_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) word <= word_next;
  end

  // queue write: up to three tokens at once, one read per cycle while out_ready is high
  logic do_pop;
  assign do_pop = out_valid && out_ready;
  assign out_valid = (cnt != '0);
  assign out_token = qmem[rd];

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < ntok) qmem[QA'(wr + QA'(i))] <= tok[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0; wr <= '0; cnt <= '0;
    end else begin
      if (do_pop) rd <= rd + QA'(1);
      if (take) wr <= wr + QA'(ntok);
      cnt <= cnt + (take ? (QA+1)'(ntok) : '0) - (do_pop ? (QA+1)'(1) : '0);
    end
  end

endmodule

@@ sv/script_source_tokenizer.sv @@
// Top level of the source tokenizer: front classifier plus back scanner.
// Depends on sst_pkg, sst_front, sst_back.
//
// Usage:
//  s_axis carries one source byte per transfer: tdata = source_byte,
//  tuser = end_of_text. A zero byte also ends the text.
//  m_axis carries tokens: tdata = {error_code, line, length, start, kind},
//  tlast = last token caused by one input byte.
//  Each byte yields zero to three tokens. End of text flushes the pending
//  token, emits an EOF token and returns the scanner to its reset state.
//  Path: front register, then token queue, then m_axis.
//  Throughput: one byte per cycle while the token queue has room for three
//  more entries; a burst of multi-token bytes drains at one token a cycle,
//  limited by the single queue read port, while the receiver is ready.
//  Reset (rst, synchronous): scanner idle, position 0, line 1, queue empty.
//  When the receiver stalls the queue fills and s_axis_tready drops; no
//  token is lost or reordered.
module script_source_tokenizer #(
  parameter int unsigned SOURCE_BYTES = sst_pkg::SOURCE_BYTES_DEF,
  parameter int unsigned MAX_LINES    = sst_pkg::MAX_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  logic        s_axis_tuser,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // kind[5:0] start[21:6] length[37:22] line[53:38] err[56:54]
  output logic        m_axis_tlast    // last_of_run
);
  import sst_pkg::*;

  logic        q_valid, q_ready;
  byte_class_t q_data;
  token_t      tok;

  sst_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_end(s_axis_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  sst_back #(.SOURCE_BYTES(SOURCE_BYTES), .MAX_LINES(MAX_LINES)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_token(tok)
  );

  assign m_axis_tdata = {7'd0, tok.err, tok.line, tok.length, tok.start, tok.kind};
  assign m_axis_tlast = tok.last;

endmodule

@@ sv/sst_checker.sv @@
// Port-level checker for the source tokenizer, bound to the top level.
// Depends on script_source_tokenizer ports only.
module sst_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:57] == 7'd0)
    else $error("pad bits set");
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[56:54] != 3'd0 |-> m_axis_tdata[5:0] == 6'd5)
    else $error("error code on non-error token");
  a_eof: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5:0] == 6'd0 |-> m_axis_tlast)
    else $error("eof not last of run");
  a_line: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[53:38] != 16'd0)
    else $error("line zero");
endmodule

bind script_source_tokenizer sst_checker u_sst_checker (
  .clk(clk), .rst(rst),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

@@ bench/tok_checker.sv @@
// Token checker: follows accepted source bytes, predicts the tokens they cause
// and compares each emitted token with the oldest prediction. Uses sst_pkg.
module tok_checker
  import sst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          tokens_pending
);

  localparam int unsigned POS_MAX  = 65535;
  localparam int unsigned LINE_MAX = 65535;

  token_t     token_fifo[$];
  token_t     step_toks[$];
  scan_mode_t mode;
  int unsigned pos, line, tbeg, wlen, stopped;
  logic [7:0] wbuf[WORD_MAX];

  function automatic bit digit_c(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic clear_state();
    mode = M_IDLE; pos = 0; line = 1; tbeg = 0; wlen = 0; stopped = 0;
  endtask

  task automatic push_tok(input logic [5:0] k, input int unsigned st, input int unsigned len,
                          input logic [2:0] e);
    token_t t;
    if (step_toks.size() >= 3) return;
    t.kind = k; t.start = st[15:0]; t.length = len > 65535 ? 16'hFFFF : len[15:0];
    t.line = line[15:0]; t.err = e; t.last = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic push_span(input logic [5:0] k, input int unsigned fin, input logic [2:0] e);
    push_tok(k, tbeg, fin > tbeg ? fin - tbeg : 0, e);
  endtask

  task automatic next_line();
    if (line < LINE_MAX) line++;
  endtask

  // Keyword lookup against the buffered word.
  function automatic logic [5:0] kind_of_word();
    string kw[23] = '{"abstract", "break", "class", "continue", "else", "if", "nil",
      "return", "super", "switch", "static", "var", "while", "false", "for", "fun",
      "final", "this", "true", "override", "public", "private", "protected"};
    string w;
    w = "";
    if (wlen > WORD_MAX) return K_IDENT;
    for (int i = 0; i < wlen; i++) w = {w, string'(wbuf[i])};
    for (int i = 0; i < 23; i++) if (kw[i] == w) return K_KW0 + 6'(i);
    return K_IDENT;
  endfunction

  // First byte of an operator pair -> pending mode, or M_IDLE if none.
  function automatic scan_mode_t pair_mode(input logic [7:0] c);
    case (c)
      "&": return M_OP_AND;
      "|": return M_OP_OR;
      ".": return M_OP_DOT;
      "-": return M_OP_MINUS;
      "+": return M_OP_PLUS;
      "*": return M_OP_STAR;
      "!": return M_OP_BANG;
      "=": return M_OP_EQ;
      "<": return M_OP_LT;
      ">": return M_OP_GT;
      default: return M_IDLE;
    endcase
  endfunction

  function automatic logic [7:0] pair_next(input scan_mode_t m);
    case (m)
      M_OP_AND: return "&";
      M_OP_OR:  return "|";
      M_OP_DOT: return ".";
      default:  return "=";
    endcase
  endfunction

  function automatic logic [5:0] pair_single(input scan_mode_t m);
    case (m)
      M_OP_AND: return 6'd54;   M_OP_OR: return 6'd56;   M_OP_DOT: return K_DOT;
      M_OP_MINUS: return 6'd37; M_OP_PLUS: return 6'd39; M_OP_STAR: return 6'd43;
      M_OP_BANG: return 6'd46;  M_OP_EQ: return 6'd48;   M_OP_LT: return 6'd50;
      default: return 6'd52;
    endcase
  endfunction

  task automatic begin_token(input logic [7:0] c);
    tbeg = pos;
    mode = M_IDLE;
    if (c == " " || c == 8'h0D || c == 8'h09) return;
    if (c == 8'h0A) begin next_line(); return; end
    if (digit_c(c)) begin mode = M_INT; return; end
    if (alpha_c(c)) begin wbuf[0] = c; wlen = 1; mode = M_IDENT; return; end
    if (c == 8'h22) begin mode = M_STRING; return; end
    if (c == 8'h27) begin mode = M_CHAROPEN; return; end
    if (c == "/") begin mode = M_SLASH; return; end
    if (pair_mode(c) != M_IDLE) begin mode = pair_mode(c); return; end
    case (c)
      "(": push_tok(K_LPAREN, tbeg, 1, E_NONE);
      ")": push_tok(K_RPAREN, tbeg, 1, E_NONE);
      "{": push_tok(K_LBRACE, tbeg, 1, E_NONE);
      "}": push_tok(K_RBRACE, tbeg, 1, E_NONE);
      ";": push_tok(K_SEMI, tbeg, 1, E_NONE);
      ",": push_tok(K_COMMA, tbeg, 1, E_NONE);
      ":": push_tok(K_COLON, tbeg, 1, E_NONE);
      default: push_tok(K_ERROR, tbeg, 1, E_UNEXPECTED);
    endcase
  endtask

  function automatic int unsigned dot_at();
    return pos > tbeg ? pos - 1 : tbeg;
  endfunction

  task automatic scan_byte(input logic [7:0] c);
    int unsigned dp;
    case (mode)
      M_IDENT: begin
        if (alpha_c(c) || digit_c(c)) begin
          if (wlen < WORD_MAX) wbuf[wlen] = c;
          if (wlen < 15) wlen++;
        end else begin
          push_span(kind_of_word(), pos, E_NONE); begin_token(c);
        end
      end
      M_INT: begin
        if (c == ".") mode = M_NUMDOT;
        else if (!digit_c(c)) begin push_span(K_NUMBER, pos, E_NONE); begin_token(c); end
      end
      M_NUMDOT: begin
        if (digit_c(c)) mode = M_FRAC;
        else begin
          dp = dot_at();
          push_span(K_NUMBER, dp, E_NONE);
          if (c == ".") begin
            push_tok(K_RANGE, dp, pos + 1 - dp, E_NONE); mode = M_IDLE;
          end else begin
            push_tok(K_DOT, dp, 1, E_NONE); begin_token(c);
          end
        end
      end
      M_FRAC:
        if (!digit_c(c)) begin push_span(K_NUMBER, pos, E_NONE); begin_token(c); end
      M_STRING: begin
        if (c == 8'h22) begin push_span(K_STRING, pos + 1, E_NONE); mode = M_IDLE; end
        else if (c == 8'h0A) next_line();
      end
      M_CHAROPEN: begin
        if (c == 8'h27) begin push_span(K_ERROR, pos, E_EMPTY_CHAR); begin_token(c); end
        else mode = M_CHARBODY;
      end
      M_CHARBODY: begin
        if (c == 8'h27) begin push_span(K_CHAR, pos + 1, E_NONE); mode = M_IDLE; end
        else begin push_span(K_ERROR, pos, E_NO_QUOTE); begin_token(c); end
      end
      M_SLASH: begin
        if (c == "/") begin tbeg = pos; mode = M_LINESTART; end
        else if (c == "*") mode = M_BLOCK;
        else if (c == "=") begin push_span(K_SLASHEQ, pos + 1, E_NONE); mode = M_IDLE; end
        else begin push_span(K_SLASH, pos, E_NONE); begin_token(c); end
      end
      M_LINESTART: begin
        if (c == "*") begin stopped = 1; mode = M_IDLE; end
        else if (c == 8'h0A) begin next_line(); mode = M_IDLE; end
        else mode = M_LINE;
      end
      M_LINE: if (c == 8'h0A) begin next_line(); mode = M_IDLE; end
      M_BLOCK: begin
        if (c == "*") mode = M_BLOCKSTAR;
        else if (c == 8'h0A) next_line();
      end
      M_BLOCKSTAR: begin
        if (c == "/") mode = M_IDLE;
        else if (c == 8'h0A) begin next_line(); mode = M_BLOCK; end
        else if (c != "*") mode = M_BLOCK;
      end
      M_IDLE: begin_token(c);
      default: begin
        if (c == pair_next(mode)) begin
          push_span(pair_single(mode) + 6'd1, pos + 1, E_NONE); mode = M_IDLE;
        end else begin
          push_span(pair_single(mode), pos, E_NONE); begin_token(c);
        end
      end
    endcase
  endtask

  task automatic flush_pending();
    int unsigned dp;
    case (mode)
      M_IDENT: push_span(kind_of_word(), pos, E_NONE);
      M_INT, M_FRAC: push_span(K_NUMBER, pos, E_NONE);
      M_NUMDOT: begin
        dp = dot_at();
        push_span(K_NUMBER, dp, E_NONE);
        push_tok(K_DOT, dp, 1, E_NONE);
      end
      M_STRING: push_span(K_ERROR, pos, E_UNTERM_STR);
      M_CHAROPEN, M_CHARBODY: push_span(K_ERROR, pos, E_NO_QUOTE);
      M_SLASH: push_span(K_SLASH, pos, E_NONE);
      M_IDLE, M_LINESTART, M_LINE, M_BLOCK, M_BLOCKSTAR: ;
      default: push_span(pair_single(mode), pos, E_NONE);
    endcase
  endtask

  task automatic predict(input logic [7:0] c, input logic eot);
    int unsigned eof_at;
    step_toks.delete();
    if (eot || c == 8'h00) begin
      eof_at = stopped ? tbeg : pos;
      if (!stopped) flush_pending();
      push_tok(K_EOF, eof_at, 0, E_NONE);
      clear_state();
    end else if (!stopped) begin
      scan_byte(c);
      if (pos < POS_MAX) pos++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) token_fifo.push_back(step_toks[i]);
  endtask

  always @(posedge clk) begin
    token_t want, got;
    if (rst) begin
      clear_state();
      token_fifo.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tdata[37:22],
               m_axis_tdata[53:38], m_axis_tdata[56:54], m_axis_tlast};
        if (token_fifo.size() == 0) begin
          report("unexpected token", 64'(got), '0);
        end else begin
          want = token_fifo.pop_front();
          if (got.kind != want.kind) report("kind", got.kind, want.kind);
          if (got.start != want.start) report("start", got.start, want.start);
          if (got.length != want.length) report("length", got.length, want.length);
          if (got.line != want.line) report("line", got.line, want.line);
          if (got.err != want.err) report("error code", got.err, want.err);
          if (got.last != want.last) report("tlast", got.last, want.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict(s_axis_tdata, s_axis_tuser);
    end
    tokens_pending = token_fifo.size();
  end

  initial fail_count = 0;

endmodule

@@ bench/tb_script_source_tokenizer.sv @@
// Top of the tokenizer bench: clock, reset, source byte stimulus, token sink
// with random stalls, and the verdict. Depends on tok_checker and the block.
module tb_script_source_tokenizer;
  import sst_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count, tokens_pending;
  int          cycle = 0;
  bit          hold_sink = 1'b0;   // long receiver hold-off to back up the queue
  bit          stim_done = 1'b0;

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  script_source_tokenizer dut (.*);

  tok_checker chk (.*);

  // Gap length: mostly 0-2, now and then a long one.
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Send one byte and hold it until transferred; random gap afterwards
  // unless this phase runs back to back.
  task automatic send_byte(input logic [7:0] b, input logic eot, input bit no_gap);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eot;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit no_gap);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, no_gap);
  endtask

  // Random well-formed-ish program fragment.
  function automatic string rand_piece();
    string pieces[] = '{"abstract", "break", "class", "continue", "else", "if", "nil",
      "return", "super", "switch", "static", "var", "while", "false", "for", "fun",
      "final", "this", "true", "override", "public", "private", "protected",
      "abstracts", "protecte", "x1", "_tmp", "veryLongName12", "42", "3.14", "7.",
      "1..9", "\"str\"", "\"a\nb\"", "'c'", "''", "'ab", "'\n'", "// note\n",
      "/* blk\n** */", "( )", "{ }", ";", ",", ":", "&&", "&", "||", "|", "..", ".",
      "-=", "-", "+=", "+", "*=", "*", "!=", "!", "==", "=", "<=", "<", ">=", ">",
      "/", "/=", "@", "#", " ", "\t", "\r", "\n"};
    return pieces[$urandom_range(0, pieces.size() - 1)];
  endfunction

  task automatic send_random_program(input bit no_gap);
    int n;
    logic [7:0] b;
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise byte: any nonzero value
        b = 8'($urandom_range(1, 255));
        send_byte(b, 1'b0, no_gap);
      end else begin
        send_text(rand_piece(), no_gap);
        if ($urandom_range(0, 1)) send_byte(" ", 1'b0, no_gap);
      end
    end
    case ($urandom_range(0, 3))
      0: send_byte(8'h00, 1'b0, no_gap);
      default: send_byte(8'($urandom), 1'b1, no_gap);
    endcase
  endtask

  // Sink: random stalls, plus the one long hold-off.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else begin
        g = gap_len();
        if ($urandom_range(0, 2) == 0 && g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g - 1) @(posedge clk);
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int drain;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: keywords, operators, numbers, char/string errors, comments.
    send_text("protected abstract x;(a,b):{}", 1'b0);
    send_text("1..2 3.5 7.x &&&||.-=+=*=!===<=>=/=/ @", 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_text("'' 'a' 'ab\"s\ntr\" /*c\n*/ //l\n", 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_text("12.", 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_text("\"open", 1'b0);
    send_byte(8'hA5, 1'b1, 1'b0);
    send_text("a //* junk (", 1'b0);
    send_byte(8'h7F, 1'b1, 1'b0);
    send_text("/* open", 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);

    // Pressure: receiver holds off while the sender keeps going.
    fork
      begin
        hold_sink = 1'b1;
        repeat (60) @(posedge clk);
        hold_sink = 1'b0;
      end
      send_text("(){};,:(){};,:(){};,:", 1'b1);
    join
    send_byte(8'h00, 1'b1, 1'b0);

    // Random programs; some run back to back.
    for (int p = 0; p < 11; p++) send_random_program($urandom_range(0, 3) == 0);

    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    drain = 0;
    while (tokens_pending != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && tokens_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
